// ----- rtl/core/tfd_pkg.sv -----
package tfd_pkg;

  // Link control bytes
  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;

  // Result kinds carried on tuser
  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Output word layout
  localparam int unsigned OUT_DATA_W = 64;

  // Parse phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_SENSOR = 10'b00_0000_0010,
    PH_FRAME  = 10'b00_0000_0100,
    PH_APP0   = 10'b00_0000_1000,
    PH_APP1   = 10'b00_0001_0000,
    PH_DATA0  = 10'b00_0010_0000,
    PH_DATA1  = 10'b00_0100_0000,
    PH_DATA2  = 10'b00_1000_0000,
    PH_DATA3  = 10'b01_0000_0000,
    PH_CHECK  = 10'b10_0000_0000
  } phase_t;

  // Result of one parse step
  typedef struct packed {
    logic        emit;
    logic        kind;
    logic [7:0]  dev_id;
    logic [7:0]  frame_type;
    logic [15:0] app_id;
    logic [31:0] payload;
  } step_res_t;

endpackage

// ----- rtl/core/tfd_parser.sv -----
module tfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output tfd_pkg::step_res_t res
);
  import tfd_pkg::*;

  phase_t      phase, phase_next;
  logic        esc_pending, esc_pending_next;
  logic [7:0]  dev_id, dev_id_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  sum, sum_next;
  logic [15:0] app_id, app_id_next;
  logic [31:0] payload, payload_next;

  logic [7:0]  data_b;
  logic [8:0]  sum_wide;
  logic [7:0]  sum_added;

  // Unescape and end-around-carry add
  assign data_b    = esc_pending ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
  assign sum_wide  = {1'b0, sum} + {1'b0, data_b};
  assign sum_added = sum_wide[7:0] + {7'd0, sum_wide[8]};

  // Decode one byte against the current phase
  always_comb begin
    phase_next       = phase;
    esc_pending_next = esc_pending;
    dev_id_next      = dev_id;
    frame_type_next  = frame_type;
    sum_next         = sum;
    app_id_next      = app_id;
    payload_next     = payload;
    res              = '0;
    if (rx_byte == START_BYTE) begin
      phase_next       = PH_SENSOR;
      esc_pending_next = 1'b0;
    end else begin
      unique case (phase) inside
        PH_SENSOR: begin
          dev_id_next  = rx_byte;
          phase_next   = PH_FRAME;
          res.emit     = 1'b1;
          res.kind     = KIND_POLL;
          res.dev_id   = rx_byte;
        end
        PH_FRAME: begin
          frame_type_next = rx_byte;
          sum_next        = rx_byte;
          phase_next      = PH_APP0;
        end
        PH_APP0, PH_APP1, PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3, PH_CHECK: begin
          if (rx_byte == ESCAPE_BYTE) begin
            esc_pending_next = 1'b1;
          end else begin
            esc_pending_next = 1'b0;
            if (phase != PH_CHECK) begin
              sum_next = sum_added;
            end
            case (phase)
              PH_APP0: begin
                app_id_next[7:0] = data_b;
                phase_next       = PH_APP1;
              end
              PH_APP1: begin
                app_id_next[15:8] = data_b;
                phase_next        = PH_DATA0;
              end
              PH_DATA0: begin
                payload_next[7:0] = data_b;
                phase_next        = PH_DATA1;
              end
              PH_DATA1: begin
                payload_next[15:8] = data_b;
                phase_next         = PH_DATA2;
              end
              PH_DATA2: begin
                payload_next[23:16] = data_b;
                phase_next          = PH_DATA3;
              end
              PH_DATA3: begin
                payload_next[31:24] = data_b;
                phase_next          = PH_CHECK;
              end
              default: begin
                // check byte: emit on match, drop otherwise
                phase_next = PH_IDLE;
                if (data_b == ~sum) begin
                  res.emit       = 1'b1;
                  res.kind       = KIND_FRAME;
                  res.dev_id     = dev_id;
                  res.frame_type = frame_type;
                  res.app_id     = app_id;
                  res.payload    = payload;
                end
              end
            endcase
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      esc_pending <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      esc_pending <= esc_pending_next;
    end
  end

  // Held frame fields
  always_ff @(posedge clk) begin
    if (step) begin
      dev_id     <= dev_id_next;
      frame_type <= frame_type_next;
      sum        <= sum_next;
      app_id     <= app_id_next;
      payload    <= payload_next;
    end
  end

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    step && rx_byte == START_BYTE |=> phase == PH_SENSOR && !esc_pending)
    else $error("start byte did not restart parsing");

  a_poll_from_sensor: assert property (@(posedge clk) disable iff (rst)
    res.emit && res.kind == KIND_POLL |-> phase == PH_SENSOR)
    else $error("poll emitted outside sensor id phase");

  a_frame_from_check: assert property (@(posedge clk) disable iff (rst)
    res.emit && res.kind == KIND_FRAME |-> phase == PH_CHECK && rx_byte != ESCAPE_BYTE)
    else $error("frame emitted outside check phase");

  a_check_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_CHECK && rx_byte != START_BYTE && rx_byte != ESCAPE_BYTE
    |=> phase == PH_IDLE)
    else $error("check byte did not end the frame");

endmodule

// ----- rtl/core/telemetry_frame_deframer_core.sv -----
// Telemetry link deframer.
// Slave stream s_axis_* carries received link bytes, one per word. Master
// stream m_axis_* carries results: a poll word right after each sensor id
// byte (tuser = 0) and a frame word for each frame whose check byte matches
// (tuser = 1). Frames with a bad check produce nothing.
// Each accepted byte lands in an input register; from there the parser decodes
// it and loads any result into the output register, waiting while that register
// still holds an unaccepted word.
// Throughput is one byte per cycle while the receiver takes results; the
// parser is a single state step per byte, so nothing else limits the rate.
// When the receiver stalls, a pending result is held and one more byte is
// taken into the input register; tready then drops until the result leaves,
// unless the held byte produces no result, in which case it is consumed.
// Reset (rst, synchronous) empties both registers and returns the parser to
// waiting for a start byte.
module telemetry_frame_deframer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] sensor id, [15:8] frame type, [31:16] app_id, [63:32] payload
  output logic [tfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tuser   // [0] event_kind
);
  import tfd_pkg::*;

  logic      in_valid;
  logic [7:0] in_byte;
  logic      out_free;
  logic      advance;
  step_res_t res;

  // Step the parser when the result (if any) has room
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (out_free || !res.emit);
  assign s_axis_tready = !in_valid || advance;

  tfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && res.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_axis_tuser <= res.kind;
      m_axis_tdata <= {res.payload, res.app_id, res.frame_type, res.dev_id};
    end
  end

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |=> m_axis_tvalid)
    else $error("result lost on its way to the output register");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("empty input register refused a byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |-> out_free)
    else $error("result overwrote a pending output word");

  a_held_byte_stays: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled byte was not held");

endmodule

// ----- bench/telemetry_frame_deframer_core_tb.sv -----
module telemetry_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 400;

  // One decoded result as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [7:0]  dev_id;
    logic [7:0]  frame_type;
    logic [15:0] app_id;
    logic [31:0] payload;
  } report_t;

  // One link byte to send; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic       emit;
    report_t    rep;
  } row_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD, FRAME_CUT} frame_kind_e;

  localparam report_t NO_REP = '0;

  localparam row_t DIRECTED [0:27] = '{
    // byte while idle is ignored
    '{8'h00, 1'b0, 1'b0, NO_REP},
    // lowest sensor id, all-ones content, check byte zero
    '{START_BYTE, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b1, 1'b1, '{KIND_POLL, 8'h00, 8'h00, 16'h0000, 32'h0000_0000}},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b1, 1'b1, '{KIND_FRAME, 8'h00, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF}},
    // escape byte as sensor id and frame type is plain data
    '{START_BYTE, 1'b0, 1'b0, NO_REP},
    '{ESCAPE_BYTE, 1'b1, 1'b1, '{KIND_POLL, 8'h7D, 8'h00, 16'h0000, 32'h0000_0000}},
    '{ESCAPE_BYTE, 1'b0, 1'b0, NO_REP},
    // escaped start byte in the app id
    '{ESCAPE_BYTE, 1'b0, 1'b0, NO_REP},
    '{8'h5E, 1'b0, 1'b0, NO_REP},
    // escape after escape, then a start byte with the escape still pending
    '{ESCAPE_BYTE, 1'b0, 1'b0, NO_REP},
    '{ESCAPE_BYTE, 1'b0, 1'b0, NO_REP},
    '{START_BYTE, 1'b0, 1'b0, NO_REP},
    // highest sensor id, zero content, bad check drops the frame
    '{8'hFF, 1'b1, 1'b1, '{KIND_POLL, 8'hFF, 8'h00, 16'h0000, 32'h0000_0000}},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b1, 1'b0, NO_REP}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // Deframer state mirrored for prediction
  phase_t      phase_q  = PH_IDLE;
  logic        esc_q    = 1'b0;
  logic [7:0]  sid_q    = '0;
  logic [7:0]  fid_q    = '0;
  logic [7:0]  sum_q    = '0;
  logic [15:0] app_q    = '0;
  logic [31:0] data_q   = '0;

  row_t    wire_bytes[$];
  report_t pending_reports[$];
  int      bytes_taken = 0;
  int      errors      = 0;
  int      cycles      = 0;

  telemetry_frame_deframer_core uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // 8-bit sum with end-around carry
  function automatic logic [7:0] wrap_sum(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, acc} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  // Advance the mirrored parser by one link byte
  function automatic void parse_byte(input logic [7:0] raw, output logic hit,
                                     output report_t rep);
    logic [7:0] v;
    v   = raw;
    hit = 1'b0;
    rep = '0;
    if (v == START_BYTE) begin
      phase_q = PH_SENSOR;
      esc_q   = 1'b0;
      return;
    end
    case (phase_q)
      PH_SENSOR: begin
        sid_q      = v;
        phase_q    = PH_FRAME;
        hit        = 1'b1;
        rep.kind   = KIND_POLL;
        rep.dev_id = v;
      end
      PH_FRAME: begin
        fid_q   = v;
        sum_q   = v;
        phase_q = PH_APP0;
      end
      PH_APP0, PH_APP1, PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3, PH_CHECK: begin
        // drop the escape itself, unmask the byte after it
        if (v == ESCAPE_BYTE) begin
          esc_q = 1'b1;
          return;
        end
        if (esc_q) begin
          v     = v ^ ESCAPE_XOR;
          esc_q = 1'b0;
        end
        if (phase_q != PH_CHECK) sum_q = wrap_sum(sum_q, v);
        case (phase_q)
          PH_APP0: begin
            app_q[7:0] = v;
            phase_q    = PH_APP1;
          end
          PH_APP1: begin
            app_q[15:8] = v;
            phase_q     = PH_DATA0;
          end
          PH_DATA0: begin
            data_q[7:0] = v;
            phase_q     = PH_DATA1;
          end
          PH_DATA1: begin
            data_q[15:8] = v;
            phase_q      = PH_DATA2;
          end
          PH_DATA2: begin
            data_q[23:16] = v;
            phase_q       = PH_DATA3;
          end
          PH_DATA3: begin
            data_q[31:24] = v;
            phase_q       = PH_CHECK;
          end
          default: begin
            phase_q = PH_IDLE;
            if (v == 8'hFF - sum_q) begin
              hit = 1'b1;
              rep = '{KIND_FRAME, sid_q, fid_q, app_q, data_q};
            end
          end
        endcase
      end
      default: phase_q = PH_IDLE;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random byte leaning toward control codes and extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return START_BYTE;
      1: return ESCAPE_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      4: return START_BYTE ^ ESCAPE_XOR;
      5: return ESCAPE_BYTE ^ ESCAPE_XOR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    wire_bytes.push_back('{b, 1'b0, 1'b0, NO_REP});
  endfunction

  // Encode one body byte, escaping control codes and now and then a plain byte
  function automatic void push_body(input logic [7:0] v);
    logic must, may;
    must = (v == START_BYTE) || (v == ESCAPE_BYTE);
    may  = ((v ^ ESCAPE_XOR) != START_BYTE) && ((v ^ ESCAPE_XOR) != ESCAPE_BYTE)
           && ($urandom_range(0, 19) == 0);
    if (must || may) begin
      if ($urandom_range(0, 9) == 0) push_byte(ESCAPE_BYTE);
      push_byte(ESCAPE_BYTE);
      push_byte(v ^ ESCAPE_XOR);
    end else begin
      push_byte(v);
    end
  endfunction

  // Build one frame on the wire; return the number of bytes it took
  function automatic int gen_frame(input frame_kind_e kind);
    logic [7:0] sid, fid, sum, chk;
    logic [7:0] body [0:5];
    int n0, cut;
    n0 = wire_bytes.size();
    do sid = pick_byte(); while (sid == START_BYTE);
    do fid = pick_byte(); while (fid == START_BYTE);
    sum = fid;
    for (int i = 0; i < 6; i++) begin
      body[i] = pick_byte();
      sum     = wrap_sum(sum, body[i]);
    end
    chk = 8'hFF - sum;
    if (kind == FRAME_BAD) chk = chk ^ 8'($urandom_range(1, 255));
    cut = (kind == FRAME_CUT) ? $urandom_range(1, 8) : 9;
    push_byte(START_BYTE);
    push_byte(sid);
    if (cut >= 2) push_byte(fid);
    for (int i = 0; i < 6; i++)
      if (cut >= 3 + i) push_body(body[i]);
    if (cut == 9) push_body(chk);
    return wire_bytes.size() - n0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Stimulus and run control
  initial begin : main
    int  gap;
    int  frame_bytes;
    int  r;
    bit  burst;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    for (int i = 0; i < $size(DIRECTED); i++) wire_bytes.push_back(DIRECTED[i]);
    frame_bytes = 0;
    while (frame_bytes < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 72) frame_bytes += gen_frame(FRAME_GOOD);
      else if (r < 84) frame_bytes += gen_frame(FRAME_BAD);
      else if (r < 94) frame_bytes += gen_frame(FRAME_CUT);
      else repeat ($urandom_range(1, 6)) push_byte(pick_byte());
    end

    repeat (5) @(posedge clk);
    rst   <= 1'b0;
    burst = 1'b0;

    // Offer each word, with random gaps and gap-free bursts
    for (int i = 0; i < wire_bytes.size(); i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= wire_bytes[i].data;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;

    // Drain remaining results, then allow for stray words
    while (bytes_taken < wire_bytes.size() || pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: ready stretches, random stalls, one long hold-off
  initial begin : receiver
    int stretch;
    int hold;
    int rounds;
    m_axis_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    rounds = 0;
    forever begin
      stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
      m_axis_tready <= 1'b1;
      repeat (stretch) @(posedge clk);
      rounds++;
      hold = (rounds == 40) ? LONG_HOLD : pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Predict on accepted bytes, compare accepted result words
  always @(posedge clk) begin : monitor
    logic    hit;
    report_t pred;
    report_t got;
    report_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, hit, pred);
        if (wire_bytes[bytes_taken].typed) begin
          if (wire_bytes[bytes_taken].emit) pending_reports.push_back(wire_bytes[bytes_taken].rep);
        end else if (hit) begin
          pending_reports.push_back(pred);
        end
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind       = m_axis_tuser;
        got.dev_id     = m_axis_tdata[7:0];
        got.frame_type = m_axis_tdata[15:8];
        got.app_id     = m_axis_tdata[31:16];
        got.payload    = m_axis_tdata[63:32];
        if (pending_reports.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %0h", $time, got);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(got.kind));
          check_field("dev_id", 32'(want.dev_id), 32'(got.dev_id));
          check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
          check_field("app_id", 32'(want.app_id), 32'(got.app_id));
          check_field("payload", want.payload, got.payload);
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ----- telemetry_frame_deframer_core.f -----
rtl/core/tfd_pkg.sv
rtl/core/tfd_parser.sv
rtl/core/telemetry_frame_deframer_core.sv
bench/telemetry_frame_deframer_core_tb.sv
